>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the subset-sum block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("epss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("epss assertion failed");

`endif

>>> rtl/epss_pkg.sv
// ----------------------------------------------------------------------------
// Subset-sum package
// Field widths, parameter defaults and the cell control bundle.
// ----------------------------------------------------------------------------
package epss_pkg;

	// Fixed field widths of the item and result beats.
	localparam int VALUE_W = 8;
	localparam int TOTAL_W = 11;

	// Parameter defaults for the top level.
	localparam int DEF_MAX_TOTAL = 2047;
	localparam int DEF_MAX_VALUE = 255;

	// Control broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic clear;
		logic load;
		logic shift;
		logic merge;
	} cell_ctl_t;

endpackage

>>> rtl/epss_if.sv
// ----------------------------------------------------------------------------
// Subset-sum channel interfaces
// Valid/ready channels for input elements and partition results.
// ----------------------------------------------------------------------------

// One set element per beat.
interface epss_item_if import epss_pkg::*;;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink (input valid, input value, input is_last, output ready);
endinterface

// One partition verdict per set.
interface epss_result_if import epss_pkg::*;;
	logic               valid;
	logic               ready;
	logic               can_split;
	logic               total_odd;
	logic               overflow;
	logic [TOTAL_W-1:0] total;

	modport source (output valid, output can_split, output total_odd, output overflow,
		output total, input ready);
	modport sink (input valid, input can_split, input total_odd, input overflow,
		input total, output ready);
endinterface

>>> rtl/epss_cell.sv
// ----------------------------------------------------------------------------
// Subset-sum cell
// Holds one reachable-sum bit and one bit of the shifting copy.
// ----------------------------------------------------------------------------
module epss_cell import epss_pkg::*; #(
	parameter bit RESET_SET = 1'b0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      s_in,
	output logic      s_out
);

	logic v_q;
	logic s_q;

	// Reachable bit: cleared to its start value, or merged with the shifted copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= RESET_SET;
		end else if (ctl.clear) begin
			v_q <= RESET_SET;
		end else if (ctl.shift && ctl.merge) begin
			v_q <= v_q | s_in;
		end
	end

	// Shifting copy: loaded from the reachable bit, then taken from the lower neighbor.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			s_q <= v_q;
		end else if (ctl.shift) begin
			s_q <= s_in;
		end
	end

	assign s_out = s_q;

endmodule

>>> rtl/epss_row.sv
// ----------------------------------------------------------------------------
// Subset-sum cell row
// Chains one cell per reachable sum; the copy moves up one sum per shift.
// ----------------------------------------------------------------------------
module epss_row import epss_pkg::*; #(
	parameter int SUM_BITS = DEF_MAX_TOTAL / 2 + 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	output logic      top_bit
);

	logic [SUM_BITS:0] link;

	// Sum zero has no lower neighbor and shifts in a zero.
	assign link[0] = 1'b0;

	for (genvar i = 0; i < SUM_BITS; i++) begin : g_cell
		epss_cell #(
			.RESET_SET(i == 0)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.s_in  (link[i]),
			.s_out (link[i+1])
		);
	end

	assign top_bit = link[SUM_BITS];

endmodule

>>> rtl/equal_partition_subset_sum.sv
// ----------------------------------------------------------------------------
// Equal-partition subset-sum checker
// Builds the reachable subset sums of a set in a row of cells and reports
// whether the set splits into two halves of equal sum.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat fields                                  Beats
// items     in   value[7:0], is_last                          one per element
// results   out  can_split, total_odd, overflow, total[10:0]  one per set
//
// An element of value v loads the row copy, which shifts up one sum per cycle
// and merges once it lies v sums higher; a zero element, or one that overflows
// or is met after overflow, skips the shift. After the last element, an even
// total in range is loaded again and probe shifted until total/2 reaches the top
// cell, else no probe. Reset and each set end restore the row; no clearing pass.
// A result still waiting in the output register holds the next set in its emit
// cycle, which stalls the item channel until that beat leaves.
// ----------------------------------------------------------------------------
module equal_partition_subset_sum import epss_pkg::*; #(
	parameter int MAX_TOTAL = DEF_MAX_TOTAL,
	parameter int MAX_VALUE = DEF_MAX_VALUE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	epss_item_if.sink            items,
	epss_result_if.source        results
);

	localparam int SUM_BITS = MAX_TOTAL / 2 + 1;
	localparam int IDX_W    = $clog2(SUM_BITS);
	localparam int TOT_W    = $clog2(MAX_TOTAL + 1);
	localparam int CNT_W    = (IDX_W > VALUE_W) ? IDX_W : VALUE_W;
	localparam int ACC_W    = ((TOT_W > VALUE_W) ? TOT_W : VALUE_W) + 1;
	localparam int SAT_VAL  = (MAX_VALUE < (2 ** VALUE_W - 1)) ? MAX_VALUE
		: (2 ** VALUE_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FINISH,
		ST_PROBE,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [TOT_W-1:0]   total_q;
	logic               ovf_q;
	logic               last_q;
	logic               split_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               out_split_q;
	logic               out_odd_q;
	logic               out_ovf_q;
	logic [TOTAL_W-1:0] out_total_q;

	logic               accept;
	logic [VALUE_W-1:0] vsat;
	logic [ACC_W-1:0]   sum;
	logic               sum_ovf;
	logic               emit_fire;
	logic               top_bit;
	cell_ctl_t          ctl;

	// Element saturation and the running total.
	assign accept    = items.valid && items.ready;
	assign vsat      = (items.value > VALUE_W'(SAT_VAL)) ? VALUE_W'(SAT_VAL) : items.value;
	assign sum       = ACC_W'(total_q) + ACC_W'(vsat);
	assign sum_ovf   = ovf_q || (sum > ACC_W'(MAX_TOTAL));
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || results.ready);

	assign items.ready = (state_q == ST_IDLE);

	// Row control derived from the sequencer state.
	always_comb begin
		ctl       = '0;
		ctl.load  = (accept && !sum_ovf && (vsat != '0))
			|| ((state_q == ST_FINISH) && !ovf_q && !total_q[0]);
		ctl.shift = (state_q == ST_SHIFT) || ((state_q == ST_PROBE) && (cnt_q != '0));
		ctl.merge = (state_q == ST_SHIFT) && (cnt_q == CNT_W'(1));
		ctl.clear = emit_fire;
	end

	epss_row #(
		.SUM_BITS(SUM_BITS)
	) u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.top_bit(top_bit)
	);

	// Sequencer with the running total and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			split_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_split_q <= 1'b0;
			out_odd_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
			out_total_q <= '0;
		end else begin
			if (out_valid_q && results.ready && !emit_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= items.is_last;
						if (sum_ovf) begin
							total_q <= TOT_W'(MAX_TOTAL);
							ovf_q   <= 1'b1;
						end else begin
							total_q <= TOT_W'(sum);
						end
						if (!sum_ovf && (vsat != '0)) begin
							cnt_q   <= CNT_W'(vsat);
							state_q <= ST_SHIFT;
						end else if (items.is_last) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SHIFT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= last_q ? ST_FINISH : ST_IDLE;
					end
				end
				ST_FINISH: begin
					if (ovf_q || total_q[0]) begin
						split_q <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q   <= CNT_W'(SUM_BITS - 1) - CNT_W'(total_q >> 1);
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (cnt_q == '0) begin
						split_q <= top_bit;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						out_valid_q <= 1'b1;
						out_split_q <= split_q;
						out_odd_q   <= !ovf_q && total_q[0];
						out_ovf_q   <= ovf_q;
						out_total_q <= TOTAL_W'(total_q);
						total_q     <= '0;
						ovf_q       <= 1'b0;
						last_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid     = out_valid_q;
	assign results.can_split = out_split_q;
	assign results.total_odd = out_odd_q;
	assign results.overflow  = out_ovf_q;
	assign results.total     = out_total_q;

endmodule

>>> rtl/epss_checker.sv
// ----------------------------------------------------------------------------
// Subset-sum port checker
// Watches the result channel of the subset-sum block over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epss_checker import epss_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               can_split,
	input logic               total_odd,
	input logic               overflow,
	input logic [TOTAL_W-1:0] total
);

	// A stalled result beat stays offered with the same split flag and total.
	`EPSS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(can_split) && $stable(total))

	// An overflowed set never splits and does not raise the odd-total flag.
	`EPSS_ASSERT_IMPL(a_ovf, clk, arst_n, out_valid && overflow, !can_split && !total_odd)

	// An odd total cannot split.
	`EPSS_ASSERT_IMPL(a_odd, clk, arst_n, out_valid && total_odd, !can_split)

	// Without overflow the parity flag follows the total.
	`EPSS_ASSERT_IMPL(a_par, clk, arst_n, out_valid && !overflow, total_odd == total[0])

endmodule

bind equal_partition_subset_sum epss_checker u_epss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.can_split(results.can_split),
	.total_odd(results.total_odd),
	.overflow (results.overflow),
	.total    (results.total)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Equal-partition subset-sum checker testbench
// Feeds sets of elements through the item channel and checks each verdict
// against a bit-vector model of the reachable subset sums, with random
// idling on both channels, a long result back-pressure and a drain pause.
// ----------------------------------------------------------------------------
module tb;
	import epss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SUM_BITS    = DEF_MAX_TOTAL / 2 + 1;
	localparam int ITEM_TARGET = 400;
	localparam int HOLD_CYCLES = 3000;
	localparam int TAIL_CYCLES = 1100;
	localparam int STALL_LIMIT = 20000;

	typedef logic [VALUE_W-1:0] elem_t;

	typedef struct packed {
		logic               can_split;
		logic               total_odd;
		logic               overflow;
		logic [TOTAL_W-1:0] total;
	} verdict_t;

	// Shapes of the random sets.
	typedef enum int {
		SET_WIDE,
		SET_NARROW,
		SET_MIRROR,
		SET_HEAVY,
		SET_EXTREME
	} set_kind_t;

	// Tracks the reachable sums of the current set and the verdicts still due.
	class partition_checker;
		logic [SUM_BITS-1:0] reach;
		int unsigned         run_total;
		bit                  overflowed;
		verdict_t            verdicts_due[$];
		int                  errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			reach = '0;
			reach[0] = 1'b1;
			run_total = 0;
			overflowed = 1'b0;
		endfunction

		// Folds one accepted element into the set; the final one yields a verdict.
		function void note_element(elem_t value, logic last);
			int unsigned v;
			int unsigned sum;
			verdict_t    due;
			v = value;
			if (v > DEF_MAX_VALUE)
				v = DEF_MAX_VALUE;
			sum = run_total + v;
			if (overflowed || sum > DEF_MAX_TOTAL) begin
				run_total = DEF_MAX_TOTAL;
				overflowed = 1'b1;
			end else begin
				run_total = sum;
				if (v != 0 && v < SUM_BITS)
					reach = reach | (reach << v);
			end
			if (!last)
				return;
			due.overflow = overflowed;
			due.total_odd = overflowed ? 1'b0 : 1'(run_total % 2);
			due.can_split = !overflowed && !due.total_odd && reach[run_total / 2];
			due.total = TOTAL_W'(run_total);
			verdicts_due.push_back(due);
			restart();
		endfunction

		// Compares a result beat with the oldest verdict due.
		function void check_verdict(verdict_t got);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				$error("result beat with no verdict due: total %0d", got.total);
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			if (got.can_split !== want.can_split) begin
				$error("can_split: expected %0b, actual %0b", want.can_split, got.can_split);
				errors++;
			end
			if (got.total_odd !== want.total_odd) begin
				$error("total_odd: expected %0b, actual %0b", want.total_odd, got.total_odd);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
				errors++;
			end
			if (got.total !== want.total) begin
				$error("total: expected %0d, actual %0d", want.total, got.total);
				errors++;
			end
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	epss_item_if   items_if ();
	epss_result_if results_if ();

	equal_partition_subset_sum DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	partition_checker scb = new();

	int unsigned items_sent = 0;
	bit          steady = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned stall_cycles = 0;

	// Clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Beat monitor: predicts on accepted items, checks accepted results, and
	// ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (items_if.valid && items_if.ready)
				scb.note_element(items_if.value, items_if.is_last);
			if (results_if.valid && results_if.ready)
				scb.check_verdict({results_if.can_split, results_if.total_odd,
					results_if.overflow, results_if.total});
			if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Result receiver: random idling, or a long hold-off when requested.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				results_if.ready <= 1'b0;
				hold_left--;
			end else begin
				results_if.ready <= steady || ($urandom_range(0, 99) >= 19);
			end
		end
	end

	// Offers one element, with random idle cycles first, and waits for its beat.
	task automatic send_element(input elem_t value, input logic last);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 19) begin
			items_if.valid <= 1'b0;
			@(negedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.value <= value;
		items_if.is_last <= last;
		do
			@(posedge clk);
		while (!items_if.ready);
		items_sent++;
	endtask

	// Sends one random set of the given shape.
	task automatic send_set(input set_kind_t kind);
		int unsigned len;
		int unsigned k;
		elem_t       half [4];
		case (kind)
			SET_WIDE: begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_element(elem_t'($urandom_range(0, 255)), i == len - 1);
			end
			SET_NARROW: begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_element(elem_t'($urandom_range(0, 15)), i == len - 1);
			end
			SET_MIRROR: begin
				// Each value appears twice, so the set always splits evenly.
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++)
					half[i] = elem_t'($urandom_range(0, 255));
				for (int i = 0; i < k; i++)
					send_element(half[i], 1'b0);
				for (int i = k - 1; i >= 0; i--)
					send_element(half[i], i == 0);
			end
			SET_HEAVY: begin
				// Large values can push the total past its bound.
				len = $urandom_range(8, 12);
				for (int i = 0; i < len; i++)
					send_element(elem_t'($urandom_range(200, 255)), i == len - 1);
			end
			default: begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					send_element($urandom_range(0, 1) ? elem_t'(255) : elem_t'(0),
						i == len - 1);
			end
		endcase
	endtask

	task automatic wait_drained();
		while (scb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic set_kind_t pick_kind();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			return SET_WIDE;
		if (roll < 6)
			return SET_NARROW;
		if (roll < 8)
			return SET_MIRROR;
		if (roll < 9)
			return SET_HEAVY;
		return SET_EXTREME;
	endfunction

	// Main sequence.
	initial begin
		int unsigned set_count;
		items_if.valid = 1'b0;
		items_if.value = '0;
		items_if.is_last = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed sets: a lone zero, a lone odd maximum, an even pair, a small
		// split, the largest total in range, and a total that overflows.
		send_element(8'd0, 1'b1);
		send_element(8'd255, 1'b1);
		send_element(8'd255, 1'b0);
		send_element(8'd255, 1'b1);
		send_element(8'd1, 1'b0);
		send_element(8'd2, 1'b0);
		send_element(8'd3, 1'b1);
		repeat (8) send_element(8'd255, 1'b0);
		send_element(8'd7, 1'b1);
		repeat (8) send_element(8'd255, 1'b0);
		send_element(8'd255, 1'b1);

		// Hold the result channel off while small sets keep arriving.
		hold_req = 1'b1;
		repeat (6) begin
			for (int i = 0; i < 3; i++)
				send_element(elem_t'($urandom_range(0, 7)), i == 2);
		end

		// Pause until every verdict has come back.
		@(negedge clk);
		items_if.valid <= 1'b0;
		wait_drained();

		// Random sets, with one stretch free of idling on both sides.
		set_count = 0;
		while (items_sent < ITEM_TARGET) begin
			steady = (set_count >= 20 && set_count < 35);
			send_set(pick_kind());
			set_count++;
		end
		steady = 1'b0;
		@(negedge clk);
		items_if.valid <= 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (scb.pending() != 0) begin
			$error("%0d verdicts never arrived", scb.pending());
			scb.errors++;
		end
		if (scb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
